@@ rtl/assert_macros.svh @@
// Assertion macros shared by the frame parser RTL.
// Included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ rtl/mcfp_pkg.sv @@
// Shared types and constants for the motion-capture frame parser.
// No dependencies.
package mcfp_pkg;
  localparam logic [16:0] MAX_DGRAM = 17'd65507;
  localparam logic [16:0] SKIP_SAT  = 17'h1FFFF;
  localparam logic [15:0] SENDER_MIN = 16'd264;

  localparam logic [4:0] PH_HDR = 5'd0, PH_SENDER = 5'd1, PH_FRAME = 5'd2, PH_NSETS = 5'd3,
    PH_NAME = 5'd4, PH_NMARK = 5'd5, PH_SKIPSET = 5'd6, PH_NUNL = 5'd7, PH_SKIPUNL = 5'd8,
    PH_NRB = 5'd9, PH_ID = 5'd10, PH_POSE = 5'd11, PH_NRBM = 5'd12, PH_SKIPRBM = 5'd13,
    PH_ERR = 5'd14, PH_FLAGS = 5'd15, PH_DONE = 5'd16, PH_IGNORE = 5'd17;

  localparam logic [1:0] KIND_BODY = 2'd0, KIND_FRAME = 2'd1, KIND_SENDER = 2'd2,
    KIND_REJECT = 2'd3;
  localparam logic [1:0] MSG_NONE = 2'd0, MSG_FRAME = 2'd1, MSG_SENDER = 2'd2;
  localparam logic CFG_SENDER_ID = 1'b0, CFG_FRAME_ID = 1'b1;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] frame;
    logic [31:0] body_id;
    logic [31:0] px, py, pz, rx, ry, rz, rw;
    logic [31:0] track;
  } rec_t;

  // count * unit, saturated to the skip counter range
  function automatic logic [16:0] sat_skip(input logic [31:0] cnt, input logic is12);
    logic [35:0] v;
    begin
      v = is12 ? ({4'd0, cnt} * 36'd12) : ({4'd0, cnt} << 3);
      sat_skip = (v > {19'd0, SKIP_SAT}) ? SKIP_SAT : v[16:0];
    end
  endfunction
endpackage

@@ rtl/mcfp_out_buf.sv @@
// Two-entry output queue for result records; absorbs a body plus end record.
// Depends on mcfp_pkg, assert_macros.svh.
`include "assert_macros.svh"
module mcfp_out_buf import mcfp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push0,
  input  rec_t rec0,
  input  logic push1,
  input  rec_t rec1,
  output logic room2,
  output logic out_valid,
  input  logic out_stall,
  output rec_t out_rec
);
  rec_t q_r [2];
  logic [1:0] cnt_r;
  logic pop;
  rec_t a, b;
  logic [1:0] npush;
  logic [1:0] cnt_nxt;

  assign pop = out_valid && !out_stall;
  assign out_valid = cnt_r != 2'd0;
  assign out_rec = q_r[0];
  assign room2 = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && pop);
  assign npush = {1'b0, push0} + {1'b0, push1};
  assign a = push0 ? rec0 : rec1;
  assign b = rec1;
  assign cnt_nxt = cnt_r - {1'b0, pop} + npush;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && cnt_r == 2'd2) begin
      q_r[0] <= q_r[1];
      if (npush != 2'd0) q_r[1] <= a;
    end else if (pop || cnt_r == 2'd0) begin
      // queue drains to empty on this edge; new records fill from slot 0
      if (npush != 2'd0) q_r[0] <= a;
      if (npush == 2'd2) q_r[1] <= b;
    end else if (cnt_r == 2'd1) begin
      if (npush != 2'd0) q_r[1] <= a;
    end
  end

  `ASSERT_IMPL(a_no_over, clk, rst_n, 1'b1, cnt_r != 2'd3)
  `ASSERT_IMPL(a_push_room, clk, rst_n, (npush == 2'd2), (cnt_r == 2'd0) || (cnt_r == 2'd1 && pop))
endmodule

@@ rtl/motion_capture_frame_parser_top.sv @@
// Motion-capture frame parser top: byte parser plus result queue.
// Depends on mcfp_pkg, mcfp_out_buf, assert_macros.svh.
// Latency: a result is offered the cycle after the byte that completes it is transferred, if the queue was empty.
// Throughput: one byte per cycle while the result queue has room for two records.
// Reset: synchronous active-low; clears parse state, id registers to 5/7, version to 2.7.
`include "assert_macros.svh"
module motion_capture_frame_parser_top import mcfp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_datagram_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_record_kind,
  output logic [31:0] out_frame_number,
  output logic [31:0] out_body_id,
  output logic [31:0] out_pos_x,
  output logic [31:0] out_pos_y,
  output logic [31:0] out_pos_z,
  output logic [31:0] out_rot_x,
  output logic [31:0] out_rot_y,
  output logic [31:0] out_rot_z,
  output logic [31:0] out_rot_w,
  output logic [31:0] out_tracking_word,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  logic [15:0] sid_r, fid_r;
  logic [4:0]  ph_r, ph_nxt;
  logic [1:0]  fbi_r, fbi_nxt;
  logic [31:0] fs_r, fs_nxt;
  logic [1:0]  mk_r, mk_nxt;
  logic [15:0] dsz_r, dsz_nxt;
  logic [16:0] seen_r, seen_nxt;
  logic [16:0] skip_r, skip_nxt;
  logic [31:0] oc_r, oc_nxt;
  logic [2:0]  ic_r, ic_nxt;
  logic [31:0] bf_r [8];
  logic [31:0] cf_r, cf_nxt;
  logic [7:0]  vmaj_r, vmin_r;
  logic        fail_r, fail_nxt;

  logic room2, acc, push0, push1;
  rec_t rec0, rec1, orec;
  logic [7:0] b;
  logic [31:0] word;
  logic done4, done2, bodyw;
  logic [2:0] bw_idx;
  logic [31:0] bw_val;
  logic [16:0] p, cnt;
  logic ok;
  logic [31:0] oc_dec;
  logic [16:0] sk_dec;

  assign cfg_ready = 1'b1;
  assign in_stall = !room2;
  assign acc = in_valid && !in_stall;
  assign b = in_data_byte;

  // assembled little-endian word including this byte
  always_comb begin
    word = (fbi_r == 2'd0) ? 32'd0 : fs_r;
    word = word | ({24'd0, b} << {fbi_r, 3'b000});
  end
  assign done4 = fbi_r == 2'd3;
  assign done2 = fbi_r == 2'd1;
  assign oc_dec = oc_r - 32'd1;
  assign sk_dec = skip_r - 17'd1;

  always_comb begin
    ph_nxt = ph_r; fbi_nxt = fbi_r; fs_nxt = fs_r; mk_nxt = mk_r; dsz_nxt = dsz_r;
    seen_nxt = seen_r; skip_nxt = skip_r; oc_nxt = oc_r; ic_nxt = ic_r; cf_nxt = cf_r;
    fail_nxt = fail_r; push0 = 1'b0; push1 = 1'b0; bodyw = 1'b0; bw_idx = 3'd0;
    bw_val = 32'd0; p = seen_r - 17'd4; rec0 = '0; rec1 = '0; cnt = seen_r; ok = 1'b0;
    if (seen_r < MAX_DGRAM) begin
      seen_nxt = seen_r + 17'd1;
      cnt = seen_nxt;
      if (seen_r < 17'd4) begin
        if (seen_r[0] == 1'b0) fs_nxt = {24'd0, b};
        else if (seen_r[1] == 1'b0) begin
          if ({b, fs_r[7:0]} == sid_r) mk_nxt = MSG_SENDER;
          else if ({b, fs_r[7:0]} == fid_r) mk_nxt = MSG_FRAME;
          else begin mk_nxt = MSG_NONE; fail_nxt = 1'b1; end
        end else begin
          dsz_nxt = {b, fs_r[7:0]};
          fs_nxt = 32'd0; fbi_nxt = 2'd0;
          ph_nxt = (mk_r == MSG_SENDER) ? PH_SENDER : (mk_r == MSG_FRAME) ? PH_FRAME : PH_IGNORE;
        end
      end else if (p < {1'b0, dsz_r}) begin
        if (ph_r == PH_SENDER) begin
          if (p == 17'd260) begin bodyw = 1'b1; bw_idx = 3'd0; bw_val = {24'd0, b}; end
          else if (p == 17'd261) begin bodyw = 1'b1; bw_idx = 3'd1; bw_val = {24'd0, b}; end
        end else begin
          // word fields share the byte accumulator
          if (ph_r == PH_FRAME || ph_r == PH_NSETS || ph_r == PH_NMARK || ph_r == PH_NUNL ||
              ph_r == PH_NRB || ph_r == PH_ID || ph_r == PH_POSE || ph_r == PH_NRBM ||
              ph_r == PH_ERR) begin
            fs_nxt = word; fbi_nxt = done4 ? 2'd0 : fbi_r + 2'd1;
          end else if (ph_r == PH_FLAGS) begin
            fs_nxt = word; fbi_nxt = done2 ? 2'd0 : fbi_r + 2'd1;
          end
          unique case (ph_r)
            PH_FRAME: if (done4) begin cf_nxt = word; ph_nxt = PH_NSETS; end
            PH_NSETS: if (done4) begin
              oc_nxt = word; ph_nxt = (word == 32'd0) ? PH_NUNL : PH_NAME;
            end
            PH_NAME: if (b == 8'd0) ph_nxt = PH_NMARK;
            PH_NMARK: if (done4) begin
              skip_nxt = sat_skip(word, 1'b1);
              if (skip_nxt == 17'd0) begin
                oc_nxt = oc_dec; ph_nxt = (oc_dec == 32'd0) ? PH_NUNL : PH_NAME;
              end else ph_nxt = PH_SKIPSET;
            end
            PH_SKIPSET: begin
              skip_nxt = sk_dec;
              if (sk_dec == 17'd0) begin
                oc_nxt = oc_dec; ph_nxt = (oc_dec == 32'd0) ? PH_NUNL : PH_NAME;
              end
            end
            PH_NUNL: if (done4) begin
              skip_nxt = sat_skip(word, 1'b1);
              ph_nxt = (skip_nxt == 17'd0) ? PH_NRB : PH_SKIPUNL;
            end
            PH_SKIPUNL: begin skip_nxt = sk_dec; if (sk_dec == 17'd0) ph_nxt = PH_NRB; end
            PH_NRB: if (done4) begin
              oc_nxt = word; ph_nxt = (word == 32'd0) ? PH_DONE : PH_ID;
            end
            PH_ID: if (done4) begin
              bodyw = 1'b1; bw_idx = 3'd0; bw_val = word; ic_nxt = 3'd0; ph_nxt = PH_POSE;
            end
            PH_POSE: if (done4) begin
              bodyw = 1'b1; bw_idx = ic_r + 3'd1; bw_val = word; ic_nxt = ic_r + 3'd1;
              if (ic_r == 3'd6) ph_nxt = PH_NRBM;
            end
            PH_NRBM: if (done4) begin
              skip_nxt = sat_skip(word, 1'b0);
              ph_nxt = (skip_nxt == 17'd0) ? PH_ERR : PH_SKIPRBM;
            end
            PH_SKIPRBM: begin skip_nxt = sk_dec; if (sk_dec == 17'd0) ph_nxt = PH_ERR; end
            PH_ERR: if (done4) begin
              if (vmaj_r >= 8'd2 && vmin_r >= 8'd6) ph_nxt = PH_FLAGS;
              else begin push0 = 1'b1; rec0.track = word; end
            end
            PH_FLAGS: if (done2) begin
              push0 = 1'b1; rec0.track = word[0] ? 32'h3F800000 : 32'd0;
            end
            default: ;
          endcase
          if (push0) begin
            rec0.kind = KIND_BODY; rec0.frame = cf_r; rec0.body_id = bf_r[0];
            rec0.px = bf_r[1]; rec0.py = bf_r[2]; rec0.pz = bf_r[3]; rec0.rx = bf_r[4];
            rec0.ry = bf_r[5]; rec0.rz = bf_r[6]; rec0.rw = bw_idx == 3'd7 ? bw_val : bf_r[7];
            oc_nxt = oc_dec; ph_nxt = (oc_dec == 32'd0) ? PH_DONE : PH_ID;
          end
        end
      end
    end
    if (in_datagram_end) begin
      push1 = 1'b1;
      ok = !fail_nxt && cnt > 17'd4 && {1'b0, dsz_nxt} == cnt - 17'd4 &&
           ((mk_nxt == MSG_SENDER && dsz_nxt >= SENDER_MIN) ||
            (mk_nxt == MSG_FRAME && ph_nxt == PH_DONE));
      if (!ok) rec1.kind = KIND_REJECT;
      else if (mk_nxt == MSG_SENDER) rec1.kind = KIND_SENDER;
      else begin rec1.kind = KIND_FRAME; rec1.frame = cf_nxt; end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sid_r <= 16'd5; fid_r <= 16'd7; vmaj_r <= 8'd2; vmin_r <= 8'd7; cf_r <= 32'd0;
      ph_r <= PH_HDR; fbi_r <= 2'd0; fs_r <= 32'd0; mk_r <= MSG_NONE; dsz_r <= 16'd0;
      seen_r <= 17'd0; skip_r <= 17'd0; oc_r <= 32'd0; ic_r <= 3'd0; fail_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_SENDER_ID) sid_r <= cfg_data;
        else fid_r <= cfg_data;
      end
      if (acc) begin
        cf_r <= cf_nxt;
        if (in_datagram_end) begin
          if (ok && mk_nxt == MSG_SENDER) begin
            vmaj_r <= (bodyw && bw_idx == 3'd0) ? bw_val[7:0] : bf_r[0][7:0];
            vmin_r <= (bodyw && bw_idx == 3'd1) ? bw_val[7:0] : bf_r[1][7:0];
          end
          ph_r <= PH_HDR; fbi_r <= 2'd0; fs_r <= 32'd0; mk_r <= MSG_NONE; dsz_r <= 16'd0;
          seen_r <= 17'd0; skip_r <= 17'd0; oc_r <= 32'd0; ic_r <= 3'd0; fail_r <= 1'b0;
        end else begin
          ph_r <= ph_nxt; fbi_r <= fbi_nxt; fs_r <= fs_nxt; mk_r <= mk_nxt; dsz_r <= dsz_nxt;
          seen_r <= seen_nxt; skip_r <= skip_nxt; oc_r <= oc_nxt; ic_r <= ic_nxt;
          fail_r <= fail_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && bodyw) bf_r[bw_idx] <= bw_val;
  end

  mcfp_out_buf u_buf (
    .clk(clk), .rst_n(rst_n),
    .push0(acc && push0), .rec0(rec0), .push1(acc && push1), .rec1(rec1),
    .room2(room2), .out_valid(out_valid), .out_stall(out_stall), .out_rec(orec)
  );

  assign out_record_kind = orec.kind;
  assign out_frame_number = orec.frame;
  assign out_body_id = orec.body_id;
  assign out_pos_x = orec.px;
  assign out_pos_y = orec.py;
  assign out_pos_z = orec.pz;
  assign out_rot_x = orec.rx;
  assign out_rot_y = orec.ry;
  assign out_rot_z = orec.rz;
  assign out_rot_w = orec.rw;
  assign out_tracking_word = orec.track;

  `ASSERT_IMPL(a_seen_cap, clk, rst_n, 1'b1, seen_r <= MAX_DGRAM)
  `ASSERT_NEXT(a_end_clears, clk, rst_n, acc && in_datagram_end, seen_r == 17'd0 && !fail_r)
  `ASSERT_IMPL(a_pose_idx, clk, rst_n, ph_r == PH_POSE, ic_r <= 3'd6)
endmodule
